// ----- hw/rtl/mfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types and constants of the MSP v1 frame parser.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;

    localparam logic [7:0] CH_START   = 8'h24;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_TO_FC   = 8'h3C;
    localparam logic [7:0] CH_FROM_FC = 8'h3E;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_TRUNC = 2'd1;
    localparam logic [1:0] STAT_CSUM  = 2'd2;

    typedef enum logic [3:0] {
        PH_SOF,
        PH_M,
        PH_DIR,
        PH_LEN,
        PH_CMD,
        PH_PAYLOAD,
        PH_CSUM,
        PH_RD,
        PH_OUT
    } t_phase;

endpackage

// ----- hw/rtl/mfp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/msp_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msp_frame_parser
// MSP v1 frame parser: hunts for '$' 'M' dir len cmd payload checksum frames
// and streams the stored payload out once the checksum matches.
// ----------------------------------------------------------------------------
// Header and payload bytes are taken one per cycle; payload bytes go into a
// PAYLOAD_DEPTH x 8 RAM, and bytes beyond that depth are counted and enter the
// checksum but are not stored. A matching checksum byte starts the readout:
// each stored byte takes a RAM read, then an output load that waits for the
// output side, and input is held off until the last stored byte is loaded.
// An empty payload or a checksum error gives a single result in the cycle
// after the checksum byte. The RAM needs no clearing after reset.
module msp_frame_parser
    import mfp_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = mfp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] command, [15:8] payload_length, [16] direction,
    // [22:17] byte_index, [30:23] data_byte, [31] zero
    output logic [31:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] has_data
    output logic        m_axis_tlast    // last
);

    localparam int         AW     = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [7:0] DEPTH8 = 8'(PAYLOAD_DEPTH);

    t_phase        r_phase, n_phase;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_cmd, n_cmd;
    logic          r_dir, n_dir;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;

    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;
    logic [2:0]    r_out_user, n_out_user;
    logic          r_out_last, n_out_last;

    logic          in_xfer;
    logic          out_free;
    logic          trunc;
    logic [7:0]    stored;
    logic          idx_last;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;
    logic [7:0]    b;

    assign b        = s_axis_tdata;
    assign out_free = !r_out_valid || m_axis_tready;
    assign trunc    = r_len > DEPTH8;
    assign stored   = trunc ? DEPTH8 : r_len;
    assign idx_last = (8'(r_idx) + 8'd1) == stored;

    // input held off during the payload readout, and at the checksum byte while the output holds an untaken result
    assign s_axis_tready = (r_phase == PH_CSUM) ? out_free :
                           (r_phase != PH_RD && r_phase != PH_OUT);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign ram_wr_en = in_xfer && (r_phase == PH_PAYLOAD) && (r_count < DEPTH8);
    assign ram_rd_en = (r_phase == PH_RD);

    mfp_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (b),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SOF;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_len      <= n_len;
        r_cmd      <= n_cmd;
        r_dir      <= n_dir;
        r_xor      <= n_xor;
        r_count    <= n_count;
        r_idx      <= n_idx;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_cmd       = r_cmd;
        n_dir       = r_dir;
        n_xor       = r_xor;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;

        unique case (r_phase)
            PH_SOF: begin
                if (in_xfer && b == CH_START) begin
                    n_phase = PH_M;
                end
            end
            PH_M: begin
                if (in_xfer) begin
                    n_phase = (b == CH_M) ? PH_DIR : PH_SOF;
                end
            end
            PH_DIR: begin
                if (in_xfer) begin
                    if (b == CH_FROM_FC) begin
                        n_dir   = 1'b1;
                        n_phase = PH_LEN;
                    end else if (b == CH_TO_FC) begin
                        n_dir   = 1'b0;
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_SOF;
                    end
                end
            end
            PH_LEN: begin
                if (in_xfer) begin
                    n_len   = b;
                    n_xor   = b;
                    n_count = 8'd0;
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (in_xfer) begin
                    n_cmd   = b;
                    n_xor   = r_xor ^ b;
                    n_phase = (r_len != 8'd0) ? PH_PAYLOAD : PH_CSUM;
                end
            end
            PH_PAYLOAD: begin
                if (in_xfer) begin
                    n_count = r_count + 8'd1;
                    n_xor   = r_xor ^ b;
                    if (n_count >= r_len) begin
                        n_phase = PH_CSUM;
                    end
                end
            end
            PH_CSUM: begin
                if (in_xfer) begin
                    n_phase = PH_SOF;
                    if (b == r_xor && stored != 8'd0) begin
                        n_idx   = '0;
                        n_phase = PH_RD;
                    end else begin
                        // single result: empty payload or checksum error
                        n_out_valid = 1'b1;
                        n_out_data  = {9'd0, 6'd0, r_dir, r_len, r_cmd};
                        n_out_user  = {1'b0, (b == r_xor) ? STAT_OK : STAT_CSUM};
                        n_out_last  = 1'b1;
                    end
                end
            end
            PH_RD: begin
                n_phase = PH_OUT;
            end
            PH_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, ram_rd_data, 6'(r_idx), r_dir, r_len, r_cmd};
                    n_out_user  = {1'b1, trunc ? STAT_TRUNC : STAT_OK};
                    n_out_last  = idx_last;
                    if (idx_last) begin
                        n_phase = PH_SOF;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_phase = PH_RD;
                    end
                end
            end
            default: begin
                n_phase = PH_SOF;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    a_no_input_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RD || r_phase == PH_OUT) |-> !s_axis_tready)
        else $error("input taken during payload readout");

    a_read_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RD |=> r_phase == PH_OUT)
        else $error("readout skipped the output load");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[2]) |-> r_out_last)
        else $error("result without data is not last");

    a_write_only_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_phase == PH_PAYLOAD && r_count < DEPTH8))
        else $error("store written outside payload phase");

endmodule
